>>> rtl/iwrd_pkg.sv
`default_nettype none

package iwrd_pkg;

	localparam int WINDOW_DEPTH = 64;
	localparam int NUM_REGS     = 64;
	localparam int MAX_DESTS    = 2;

	localparam int WIN_AW = $clog2(WINDOW_DEPTH);
	localparam int WIN_CW = $clog2(WINDOW_DEPTH + 1);
	localparam int REG_AW = $clog2(NUM_REGS);

	localparam int OP_W    = 2;
	localparam int SEQ_W   = 32;
	localparam int CNT_W   = 2;
	localparam int REG_W   = 6;
	localparam int OCC_W   = 7;
	localparam int CTR_W   = 8;
	localparam int ENTRY_W = 1 + CNT_W + 2 * REG_W;

	// entry holds at most two registers
	localparam int DEST_LIM = (MAX_DESTS < 2) ? MAX_DESTS : 2;

	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd0;
	localparam logic [OP_W-1:0] OP_MEMORY  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

	localparam int STEP_W = 2;
	localparam logic [STEP_W-1:0] STEP_EV_A  = 2'd0;
	localparam logic [STEP_W-1:0] STEP_EV_B  = 2'd1;
	localparam logic [STEP_W-1:0] STEP_NEW_A = 2'd2;
	localparam logic [STEP_W-1:0] STEP_NEW_B = 2'd3;

	typedef struct packed {
		logic accept;
		logic rd_ctr;
		logic wr_ctr;
		logic next_step;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic step_en;
		logic last_step;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/instruction_window_reg_dependency.sv
// A query or an unused op goes from the start cycle to the finish state, and done is registered
// from that state; a push walks the destination-counter steps, each in a read state, with a write
// state added per counter actually updated (read then write of the counter memory).
// A new transaction is taken only while the controller is idle, once the last has finished.
// Reset clears the window pointers, fill, counter valid bits and the controller; the
// done strobe is never held off, the receiver takes every result in its one cycle.
`default_nettype none

module instruction_window_reg_dependency
	import iwrd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [SEQ_W-1:0]  seq_num,
	input  wire logic [CNT_W-1:0]  dest_count,
	input  wire logic [REG_W-1:0]  dest_reg_a,
	input  wire logic [REG_W-1:0]  dest_reg_b,
	input  wire logic [REG_W-1:0]  query_reg,
	output logic                   done,
	output logic                   has_producer,
	output logic [SEQ_W-1:0]       producer_seq,
	output logic                   evicted,
	output logic [OCC_W-1:0]       occupancy
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	iwrd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	iwrd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.seq_num      (seq_num),
		.dest_count   (dest_count),
		.dest_reg_a   (dest_reg_a),
		.dest_reg_b   (dest_reg_b),
		.query_reg    (query_reg),
		.stat         (stat),
		.has_producer (has_producer),
		.producer_seq (producer_seq),
		.evicted      (evicted),
		.occupancy    (occupancy)
	);

endmodule

`default_nettype wire

>>> rtl/iwrd_ram.sv
`default_nettype none

module iwrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/iwrd_ctrl.sv
`default_nettype none

module iwrd_ctrl
	import iwrd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic [OP_W-1:0] op,
	input  wire dp_stat_t  stat,
	output ctl_cmd_t       cmd,
	output logic           busy,
	output logic           done
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_UPD_RD = 2'd1;
	localparam logic [1:0] S_UPD_WR = 2'd2;
	localparam logic [1:0] S_FIN    = 2'd3;

	logic [1:0] state_q, state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (op == OP_COMPUTE || op == OP_MEMORY) begin
						state_d = S_UPD_RD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_UPD_RD: begin
				if (stat.step_en) begin
					cmd.rd_ctr = 1'b1;
					state_d    = S_UPD_WR;
				end else if (stat.last_step) begin
					state_d = S_FIN;
				end else begin
					cmd.next_step = 1'b1;
				end
			end
			S_UPD_WR: begin
				cmd.wr_ctr = 1'b1;
				if (stat.last_step) begin
					state_d = S_FIN;
				end else begin
					cmd.next_step = 1'b1;
					state_d       = S_UPD_RD;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_FIN))
		else $error("done without finish");

	a_wr_follows_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD_WR |-> $past(state_q == S_UPD_RD))
		else $error("counter write without read");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !busy && !done_q || !busy)
		else $error("accept while busy");

endmodule

`default_nettype wire

>>> rtl/iwrd_dp.sv
`default_nettype none

module iwrd_dp
	import iwrd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctl_cmd_t          cmd,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [SEQ_W-1:0]  seq_num,
	input  wire logic [CNT_W-1:0]  dest_count,
	input  wire logic [REG_W-1:0]  dest_reg_a,
	input  wire logic [REG_W-1:0]  dest_reg_b,
	input  wire logic [REG_W-1:0]  query_reg,
	output dp_stat_t               stat,
	output logic                   has_producer,
	output logic [SEQ_W-1:0]       producer_seq,
	output logic                   evicted,
	output logic [OCC_W-1:0]       occupancy
);

	logic [OP_W-1:0]    op_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [REG_W-1:0]   ra_q, rb_q, qr_q;
	logic               ev_q;
	logic [STEP_W-1:0]  step_q;
	logic [WIN_AW-1:0]  oldest_q;
	logic [WIN_CW-1:0]  fill_q;
	logic [NUM_REGS-1:0] vld_q;

	logic               has_q;
	logic [SEQ_W-1:0]   prod_q;
	logic               evicted_q;
	logic [OCC_W-1:0]   occ_q;

	logic [ENTRY_W-1:0] ent_rdata, ent_wdata;
	logic [CTR_W-1:0]   ctr_rdata, ctr_wdata, ctr_cur;
	logic [SEQ_W-1:0]   prod_rdata;
	logic [REG_AW-1:0]  ctr_raddr, step_idx, qr_idx;

	logic [REG_W-1:0]   step_reg;
	logic               step_act, step_inc, reg_ok, qr_ok, is_push;
	logic [CNT_W-1:0]   cnt_clamp;
	logic [WIN_CW:0]    slot_sum;
	logic [WIN_AW-1:0]  slot, oldest_nxt;
	logic               is_full;

	assign is_full = (fill_q == WIN_CW'(WINDOW_DEPTH));
	assign is_push = (op_q == OP_COMPUTE) || (op_q == OP_MEMORY);
	assign cnt_clamp = (32'(dest_count) > DEST_LIM) ? CNT_W'(DEST_LIM) : dest_count;

	always_comb begin
		step_reg = ent_rdata[5:0];
		step_act = 1'b0;
		case (step_q)
			STEP_EV_A: begin
				step_reg = ent_rdata[5:0];
				step_act = ev_q && ent_rdata[14] && (ent_rdata[13:12] > 2'd0);
			end
			STEP_EV_B: begin
				step_reg = ent_rdata[11:6];
				step_act = ev_q && ent_rdata[14] && (ent_rdata[13:12] > 2'd1);
			end
			STEP_NEW_A: begin
				step_reg = ra_q;
				step_act = (op_q == OP_COMPUTE) && (cnt_q > 2'd0);
			end
			STEP_NEW_B: begin
				step_reg = rb_q;
				step_act = (op_q == OP_COMPUTE) && (cnt_q > 2'd1);
			end
			default: begin
				step_act = 1'b0;
			end
		endcase
	end

	assign reg_ok   = (32'(step_reg) < NUM_REGS);
	assign step_inc = (step_q == STEP_NEW_A) || (step_q == STEP_NEW_B);
	assign step_idx = REG_AW'(step_reg);
	assign qr_ok    = (32'(qr_q) < NUM_REGS);
	assign qr_idx   = REG_AW'(qr_q);

	assign stat.step_en   = step_act && reg_ok;
	assign stat.last_step = (step_q == STEP_NEW_B);

	assign ctr_raddr = cmd.accept ? REG_AW'(query_reg) : step_idx;
	assign ctr_cur   = vld_q[step_idx] ? ctr_rdata : '0;
	assign ctr_wdata = step_inc ? ctr_cur + CTR_W'(1) : ctr_cur - CTR_W'(1);

	assign slot_sum   = (WIN_CW + 1)'(oldest_q) + (WIN_CW + 1)'(fill_q);
	assign slot       = ev_q ? oldest_q :
		((slot_sum >= (WIN_CW + 1)'(WINDOW_DEPTH)) ?
			WIN_AW'(slot_sum - (WIN_CW + 1)'(WINDOW_DEPTH)) : WIN_AW'(slot_sum));
	assign oldest_nxt = (oldest_q == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + WIN_AW'(1);
	assign ent_wdata  = (op_q == OP_COMPUTE) ? {1'b1, cnt_q, rb_q, ra_q} : '0;

	iwrd_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (cmd.finish && is_push),
		.waddr (slot),
		.wdata (ent_wdata),
		.re    (cmd.accept),
		.raddr (oldest_q),
		.rdata (ent_rdata)
	);

	iwrd_ram #(.WIDTH(CTR_W), .DEPTH(NUM_REGS)) u_ctr_ram (
		.clk   (clk),
		.we    (cmd.wr_ctr),
		.waddr (step_idx),
		.wdata (ctr_wdata),
		.re    (cmd.accept || cmd.rd_ctr),
		.raddr (ctr_raddr),
		.rdata (ctr_rdata)
	);

	iwrd_ram #(.WIDTH(SEQ_W), .DEPTH(NUM_REGS)) u_prod_ram (
		.clk   (clk),
		.we    (cmd.wr_ctr && step_inc),
		.waddr (step_idx),
		.wdata (seq_q),
		.re    (cmd.accept),
		.raddr (REG_AW'(query_reg)),
		.rdata (prod_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q  <= '0;
			fill_q    <= '0;
			vld_q     <= '0;
			step_q    <= STEP_EV_A;
			ev_q      <= 1'b0;
			op_q      <= OP_QUERY;
			has_q     <= 1'b0;
			evicted_q <= 1'b0;
			occ_q     <= '0;
		end else begin
			if (cmd.accept) begin
				op_q   <= op;
				ev_q   <= is_full && ((op == OP_COMPUTE) || (op == OP_MEMORY));
				step_q <= STEP_EV_A;
			end
			if (cmd.next_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.wr_ctr) begin
				vld_q[step_idx] <= 1'b1;
			end
			if (cmd.finish) begin
				has_q     <= (op_q == OP_QUERY) && qr_ok && vld_q[qr_idx] && (ctr_rdata != '0);
				evicted_q <= ev_q;
				if (is_push && ev_q) begin
					oldest_q <= oldest_nxt;
					occ_q    <= OCC_W'(fill_q);
				end else if (is_push) begin
					fill_q <= fill_q + WIN_CW'(1);
					occ_q  <= OCC_W'(fill_q + WIN_CW'(1));
				end else begin
					occ_q <= OCC_W'(fill_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			seq_q <= seq_num;
			cnt_q <= cnt_clamp;
			ra_q  <= dest_reg_a;
			rb_q  <= dest_reg_b;
			qr_q  <= query_reg;
		end
		if (cmd.finish) begin
			prod_q <= ((op_q == OP_QUERY) && qr_ok && vld_q[qr_idx] && (ctr_rdata != '0)) ?
				prod_rdata : '0;
		end
	end

	assign has_producer = has_q;
	assign producer_seq = prod_q;
	assign evicted      = evicted_q;
	assign occupancy    = occ_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= WIN_CW'(WINDOW_DEPTH))
		else $error("window fill out of range");

	a_evict_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && ev_q |-> is_full && is_push)
		else $error("eviction from a window that is not full");

	a_fill_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && is_push && !ev_q |=> fill_q == $past(fill_q) + WIN_CW'(1))
		else $error("fill did not advance on push");

endmodule

`default_nettype wire
